@@ design/bbe_pkg.sv @@
// Shared types, constants and the reciprocal table of the 3x3 box blur.
package bbe_pkg;

   localparam int BBE_MAX_WIDTH  = 1024;
   localparam int CFG_WIDTH_BITS = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int CSR_ADDR_BITS  = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CHAN_BITS      = 8;
   localparam int PIXEL_BITS     = 24;
   localparam int ROW_BITS       = CFG_HEIGHT_BITS + 1;
   localparam int SUM_BITS       = 12;
   localparam int RECIP_SHIFT    = 20;
   localparam int RECIP_BITS     = RECIP_SHIFT + 1;
   localparam int COUNT_BITS     = 4;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic sum;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic slot_free;
   } status_type;

   // ceil(2^20 / count); exact floor quotient for sums below 4096
   function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] cnt);
      logic [RECIP_BITS-1:0] r;
      case (cnt)
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349526;
         4'd4:    r = 21'd262144;
         4'd6:    r = 21'd174763;
         4'd9:    r = 21'd116509;
         default: r = 21'd1048576;
      endcase
      return r;
   endfunction

endpackage

@@ design/bbe_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module bbe_ctrl import bbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !reset) state_in = ST_SHIFT;
         end
         ST_SHIFT: state_in = ST_SUM;
         ST_SUM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DONE;
         ST_DONE: begin
            // hold a finished result until the output register frees up
            if (!status.has_result || status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_SHIFT: cmd.shift = 1'b1;
         ST_SUM:   cmd.sum   = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_DONE:  cmd.emit  = status.has_result && status.slot_free;
         default: ;
      endcase
   end

endmodule

@@ design/bbe_datapath.sv @@
// Line stores, 3x3 window, position tracking, averaging and result register.
module bbe_datapath import bbe_pkg::*; #(
   parameter int MAX_WIDTH = BBE_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [PIXEL_BITS-1:0]    req_tdata,
   input  logic                     req_tuser,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [PIXEL_BITS-1:0]    rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

   logic [CFG_WIDTH_BITS-1:0]  width_ff;
   logic [CFG_HEIGHT_BITS-1:0] height_ff;
   logic [CW-1:0]              col_ff, col_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;

   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] upper_rd_ff, lower_rd_ff;
   logic [PIXEL_BITS-1:0] win_ff [9];

   logic [CW-1:0]           x_ff;
   logic [PIXEL_BITS-1:0]   px_ff;
   logic [2:0]              col_ok_ff, row_ok_ff;
   logic                    in_img_ff, last_ff;
   logic [RECIP_BITS-1:0]   recip_ff;
   logic [SUM_BITS-1:0]     sum_ff [3];
   logic [PIXEL_BITS-1:0]   quot_ff;
   logic                    rsp_valid_ff;
   logic [PIXEL_BITS-1:0]   rsp_data_ff;
   logic                    rsp_last_ff;

   logic [WW-1:0]              eff_w, w_last, x_w, x_next, cx;
   logic [CFG_HEIGHT_BITS-1:0] eff_h;
   logic [ROW_BITS-1:0]        h_r, h_last, y_off, cy;
   logic [CW-1:0]              x;
   logic                       in_img, last, wrap;
   logic                       left_ok, right_ok, top_ok, bottom_ok;
   logic [1:0]                 ncol, nrow;
   logic [COUNT_BITS-1:0]      cnt;
   logic [PIXEL_BITS-1:0]      px;
   logic [SUM_BITS-1:0]        sum_in [3];

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      eff_h  = (height_ff == '0) ? CFG_HEIGHT_BITS'(1) : height_ff;
      w_last = eff_w - WW'(1);
      h_r    = ROW_BITS'(eff_h);
      h_last = h_r - ROW_BITS'(1);
   end

   // centre of the window that this request completes
   always_comb begin
      x         = (WW'(col_ff) >= eff_w) ? '0 : col_ff;
      x_w       = WW'(x);
      x_next    = x_w + WW'(1);
      wrap      = x_next >= eff_w;
      cx        = (x != '0) ? x_w - WW'(1) : w_last;
      y_off     = (x != '0) ? ROW_BITS'(1) : ROW_BITS'(2);
      cy        = row_ff - y_off;
      in_img    = (row_ff >= y_off) && (cy < h_r);
      left_ok   = cx != '0;
      right_ok  = cx != w_last;
      top_ok    = cy != '0;
      bottom_ok = cy != h_last;
      last      = (cx == w_last) && (cy == h_last);
      ncol      = 2'd1 + 2'(left_ok) + 2'(right_ok);
      nrow      = 2'd1 + 2'(top_ok) + 2'(bottom_ok);
      cnt       = COUNT_BITS'(ncol) * COUNT_BITS'(nrow);
      px        = req_tuser ? '0 : req_tdata;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.load) begin
         if (in_img && last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = CW'(x_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_WIDTH_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[CFG_HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // line stores: read the column on accept, write it back shifted down one row
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         upper_rd_ff <= upper_mem[x];
         lower_rd_ff <= lower_mem[x];
      end
      if (cmd.shift) begin
         upper_mem[x_ff] <= lower_rd_ff;
         lower_mem[x_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= x;
         px_ff     <= px;
         col_ok_ff <= {right_ok, 1'b1, left_ok};
         row_ok_ff <= {bottom_ok, 1'b1, top_ok};
         in_img_ff <= in_img;
         last_ff   <= last;
         recip_ff  <= recip(cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (cmd.shift) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= win_ff[i+3];
         win_ff[6] <= upper_rd_ff;
         win_ff[7] <= lower_rd_ff;
         win_ff[8] <= px_ff;
      end
   end

   // masked channel sums over the in-image neighbors
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            if (col_ok_ff[i/3] && row_ok_ff[i%3]) begin
               sum_in[ch] = sum_in[ch] + SUM_BITS'(win_ff[i][ch*CHAN_BITS +: CHAN_BITS]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int ch = 0; ch < 3; ch++) sum_ff[ch] <= sum_in[ch];
      end
   end

   // floor divide by the neighbor count through its reciprocal
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         for (int ch = 0; ch < 3; ch++) begin
            quot_ff[ch*CHAN_BITS +: CHAN_BITS] <= CHAN_BITS'(
               (PROD_BITS'(sum_ff[ch]) * PROD_BITS'(recip_ff)) >> RECIP_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= quot_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.has_result = in_img_ff;
   assign status.slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;
   assign rsp_tlast         = rsp_last_ff;

endmodule

@@ design/box_blur_3x3_edge_average_core.sv @@
// Top level of the 3x3 box blur with edge-aware averaging.
//
//   port group  | direction | payload
//   req_*       | in        | tdata = pixel_red, pixel_green, pixel_blue; tuser = is_pad
//   rsp_*       | out       | tdata = blur_red, blur_green, blur_blue; tlast = frame_last
//   csr_*       | in        | index 0 image_width, index 1 image_height
//
// A request passes through these steps: accept with line store read, window shift
// with store write-back, channel sums, reciprocal multiply, result load.
// The result shows on rsp from the output register that the result load fills.
// A result waiting on rsp_tready holds in the output register while the next
// request is accepted; that one then waits in its last step.
// Reset is synchronous; the line stores hold no reset value and need no clear.
module box_blur_3x3_edge_average_core import bbe_pkg::*; #(
   parameter int MAX_WIDTH = BBE_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [PIXEL_BITS-1:0]    req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic                     req_tuser,   // [0] is_pad
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [PIXEL_BITS-1:0]    rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bbe_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/bbe_checker.sv @@
// Port-level checks of the box blur core and their bind to the top level.
module bbe_checker import bbe_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [PIXEL_BITS-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one request in flight: no accept during the shift, sum, scale and done states after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request accepted while busy");

   // a fresh result follows its request through the shift, sum, scale and done states
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 5))
      else $error("result without matching request");

endmodule

bind box_blur_3x3_edge_average_core bbe_checker u_bbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ verif/tb_box_blur_3x3_edge_average_core.sv @@
// Self-checking testbench for the 3x3 edge-aware box blur core.
module tb_box_blur_3x3_edge_average_core;
   import bbe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT      = 4000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_REQUESTS = 620;

   typedef struct packed {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic last;
      rgb_type pix;
   } blur_result_type;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_PADS_INSIDE,
      FRAME_PIXEL_FLUSH,
      FRAME_NO_FLUSH,
      FRAME_CUT
   } frame_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [PIXEL_BITS-1:0]    req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [PIXEL_BITS-1:0]    rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // blur predictor state
   rgb_type                   rows_two_back [BBE_MAX_WIDTH] = '{default: '0};
   rgb_type                   rows_one_back [BBE_MAX_WIDTH] = '{default: '0};
   rgb_type                   tap [9] = '{default: '0};
   int                        next_col = 0;
   int                        next_row = 0;
   logic [CFG_WIDTH_BITS-1:0] set_width = WIDTH_RESET;
   logic [CFG_HEIGHT_BITS-1:0] set_height = HEIGHT_RESET;

   blur_result_type blur_expect_q [$];
   int           fail_count = 0;
   int           requests_sent = 0;
   int           burst_left = 0;
   bit           sender_gaps = 1'b1;
   int           hold_seq = 0;

   box_blur_3x3_edge_average_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int eff_width();
      if (set_width == 0) return 1;
      if (set_width > BBE_MAX_WIDTH) return BBE_MAX_WIDTH;
      return int'(set_width);
   endfunction

   function automatic int eff_height();
      return (set_height == 0) ? 1 : int'(set_height);
   endfunction

   function automatic rgb_type random_pixel();
      return rgb_type'(24'($urandom));
   endfunction

   function automatic bit count_failure();
      fail_count++;
      return fail_count <= 10;
   endfunction

   // advance the predictor by one accepted request and queue its blurred pixel, if any
   task automatic predict_blur(input rgb_type pixel, input logic pad);
      int w, h, x, y, cx, cy, nx, ny, taps;
      int sum_r, sum_g, sum_b;
      rgb_type px, far_row, near_row;
      blur_result_type res;
      w = eff_width();
      h = eff_height();
      x = (next_col >= w) ? 0 : next_col;
      y = next_row;
      px = pad ? rgb_type'(24'h0) : pixel;

      far_row = rows_two_back[x];
      near_row = rows_one_back[x];
      rows_two_back[x] = near_row;
      rows_one_back[x] = px;
      for (int i = 0; i < 6; i++) tap[i] = tap[i + 3];
      tap[6] = far_row;
      tap[7] = near_row;
      tap[8] = px;

      next_col = x + 1;
      next_row = y;
      if (next_col >= w) begin
         next_col = 0;
         next_row = y + 1;
      end

      // the window center trails the newest column by one
      if (x >= 1) begin
         cx = x - 1;
         cy = y - 1;
      end else begin
         cx = w - 1;
         cy = y - 2;
      end
      if (cy < 0 || cy >= h) return;

      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      taps = 0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            nx = cx + c - 1;
            ny = cy + r - 1;
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
               sum_r += tap[c * 3 + r].red;
               sum_g += tap[c * 3 + r].green;
               sum_b += tap[c * 3 + r].blue;
               taps++;
            end
         end
      end
      res.pix.red = 8'(sum_r / taps);
      res.pix.green = 8'(sum_g / taps);
      res.pix.blue = 8'(sum_b / taps);
      res.last = (cx == w - 1) && (cy == h - 1);
      blur_expect_q.push_back(res);
      if (res.last) begin
         next_col = 0;
         next_row = 0;
      end
   endtask

   // leaves req_tvalid high; the caller sends again or lowers it in the same step
   task automatic send_pixel(input rgb_type pixel, input logic pad);
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= pixel;
      req_tuser <= pad;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      predict_blur(pixel, pad);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (blur_expect_q.size() != 0) @(posedge clock);
      // let requests with no result leave the pipeline too
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      wait_results_done();
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) set_width = value[CFG_WIDTH_BITS-1:0];
      else set_height = value;
      next_col = 0;
      next_row = 0;
   endtask

   task automatic send_frame(input int w, input int h, input frame_kind_type kind);
      int n_pixels, n_flush;
      logic pad;
      n_pixels = w * h;
      n_flush = w + 1;
      if (kind == FRAME_CUT) n_pixels = $urandom_range(1, w * h);
      if (kind == FRAME_CUT || kind == FRAME_NO_FLUSH) n_flush = 0;
      for (int i = 0; i < n_pixels; i++) begin
         pad = (kind == FRAME_PADS_INSIDE) && ($urandom_range(0, 4) == 0);
         send_pixel(random_pixel(), pad);
      end
      for (int i = 0; i < n_flush; i++)
         send_pixel(random_pixel(), kind != FRAME_PIXEL_FLUSH);
   endtask

   // requests at the reset geometry stay in row 0 and give nothing
   task automatic test_reset_config();
      repeat (4) send_pixel(random_pixel(), 1'b0);
   endtask

   task automatic test_edge_cases();
      // 3x2: corners and edges, full-scale and zero channels
      write_register(CSR_IMAGE_WIDTH, 16'd3);
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'h0180FE, 1'b0);
      send_pixel(24'hFE7F01, 1'b0);
      repeat (4) send_pixel(24'hFFFFFF, 1'b1);

      // zero width and height act as one pixel
      write_register(CSR_IMAGE_WIDTH, 16'd0);
      write_register(CSR_IMAGE_HEIGHT, 16'd0);
      send_pixel(24'hA5C3E1, 1'b0);
      repeat (2) send_pixel(24'h5A3C1E, 1'b1);

      // pad inside the frame counts black; real pixels in the flush fall outside the frame and are not summed
      write_register(CSR_IMAGE_WIDTH, 16'd2);
      write_register(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'hFFFFFF, 1'b1);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h808080, 1'b0);
      repeat (3) send_pixel(24'hFFFFFF, 1'b0);
   endtask

   task automatic test_height_limits();
      write_register(CSR_IMAGE_WIDTH, 16'd1024);
      write_register(CSR_IMAGE_HEIGHT, 16'hFFFF);
      repeat (6) send_pixel(random_pixel(), 1'b0);
      write_register(CSR_IMAGE_WIDTH, 16'd5);
      repeat (60) send_pixel(random_pixel(), 1'b0);
   endtask

   // out-of-range width clamps to the widest row; a short run stays in row 0
   task automatic test_widest_row();
      write_register(CSR_IMAGE_WIDTH, 16'hFFFF);
      write_register(CSR_IMAGE_HEIGHT, 16'd1);
      repeat (24) send_pixel(random_pixel(), 1'b0);
   endtask

   task automatic test_backpressure();
      write_register(CSR_IMAGE_WIDTH, 16'd8);
      write_register(CSR_IMAGE_HEIGHT, 16'd4);
      sender_gaps = 1'b0;
      hold_seq <= hold_seq + 1;
      repeat (2) send_frame(8, 4, FRAME_CLEAN);
      sender_gaps = 1'b1;
      wait_results_done();
   endtask

   task automatic test_random_frames();
      int first, w, h, pick;
      frame_kind_type kind;
      first = requests_sent;
      while (requests_sent - first < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 9))
            0: w = 0;
            1: w = 1;
            2: w = 2;
            3: w = 3;
            default: w = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 7))
            0: h = 0;
            1: h = 1;
            default: h = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 3))
            0: write_register(CSR_IMAGE_WIDTH, {5'($urandom), 11'(w)});
            1: write_register(CSR_IMAGE_HEIGHT, 16'(h));
            default: begin
               write_register(CSR_IMAGE_HEIGHT, 16'(h));
               write_register(CSR_IMAGE_WIDTH, {5'($urandom), 11'(w)});
            end
         endcase
         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            case (pick)
               6: kind = FRAME_PADS_INSIDE;
               7: kind = FRAME_PIXEL_FLUSH;
               8: kind = FRAME_NO_FLUSH;
               9: kind = FRAME_CUT;
               default: kind = FRAME_CLEAN;
            endcase
            send_frame(eff_width(), eff_height(), kind);
            if ($urandom_range(0, 4) == 0) wait_results_done();
         end
      end
   endtask

   // receiver: random stall levels in phases, plus a long hold on request
   always @(posedge clock) begin
      static int hold_seen = 0;
      static int hold_left = 0;
      static int phase_left = 0;
      static int stall_pct = 0;
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (phase_left == 0) begin
         phase_left = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      phase_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   always @(posedge clock) begin
      blur_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pix = rsp_tdata;
         got.last = rsp_tlast;
         if (blur_expect_q.size() == 0) begin
            if (count_failure())
               $display("%0t: blurred pixel with none pending: rgb %02h %02h %02h last %0b",
                        $time, got.pix.red, got.pix.green, got.pix.blue, got.last);
         end else begin
            want = blur_expect_q.pop_front();
            if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
                got.pix.blue !== want.pix.blue || got.last !== want.last) begin
               if (count_failure())
                  $display("%0t: blur mismatch: expected rgb %02h %02h %02h last %0b, %s",
                           $time, want.pix.red, want.pix.green, want.pix.blue, want.last,
                           $sformatf("got rgb %02h %02h %02h last %0b",
                                     got.pix.red, got.pix.green, got.pix.blue, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      static int idle_cycles = 0;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_box_blur_3x3_edge_average_core: errors");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_edge_cases();
      test_height_limits();
      test_widest_row();
      test_backpressure();
      test_random_frames();
      wait_results_done();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_box_blur_3x3_edge_average_core: clean");
      end else begin
         $display("tb_box_blur_3x3_edge_average_core: errors");
      end
      $finish;
   end

endmodule
